### rtl/core/assert_macros.svh
// Assertion macros shared by the retransmit window tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/rwt_pkg.sv
// Package with field widths, codes and control structs of the retransmit window tracker.
package rwt_pkg;

    localparam int CFG_W          = 6;
    localparam int MODE_W         = 2;
    localparam int SEQ_W          = 32;
    localparam int HANDLE_W       = 16;
    localparam int KIND_W         = 3;
    localparam int WINDOW_DEFAULT = 32;
    localparam int MAX_RESULTS    = 32;

    localparam logic [CFG_W-1:0] WIN_CFG_RESET = 6'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRACK      = 2'd0,
        MODE_ACK        = 2'd1,
        MODE_MISS       = 2'd2,
        MODE_RESEND_ALL = 2'd3
    } rwt_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRACKED      = 3'd0,
        KIND_FULL         = 3'd1,
        KIND_ACK_APPLIED  = 3'd2,
        KIND_ACK_IGNORED  = 3'd3,
        KIND_RESEND       = 3'd4
    } rwt_kind_t;

    // Slot store access for one cycle
    typedef struct packed {
        logic wr;
        logic rd;
    } rwt_store_cmd_t;

    // Occupancy flag update for one cycle
    typedef struct packed {
        logic set;
        logic set_val;
        logic clear;
    } rwt_occ_cmd_t;

endpackage

### rtl/core/retransmit_window_tracker.sv
// Top level of the retransmit window tracker: item sequencer and window state.
//
// Usage:
//   s_axis carries one command per transfer: tuser holds the mode (track, ack,
//   miss report, resend all), tdata the sequence number and packet handle.
//   m_axis carries results: tuser the result kind, tdata the resent handle,
//   tlast marks the final result of a command. cfg_we/cfg_wdata write the
//   window size; the user must write it only while the block is idle, as
//   the block does not enforce this. Commands are taken one at a time. Track
//   and ack are decided in the execute state and give their result through
//   the output register; a miss report first reads the slot memory and gives
//   a result only for an occupied in-window slot after an applied ack. Resend
//   all walks the flags slot by slot, reading handles of up to 32 occupied slots.
//   Results sit in an output register, so the next command is accepted while
//   a result waits; a stalled receiver holds the sequencer only when it must
//   emit again. Reset clears the occupancy flags at once (no sweep), the
//   window base, next expected ack and the ack flag; window size resets to 32.
`include "assert_macros.svh"
module retransmit_window_tracker
    import rwt_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)(
    input  logic                clk,
    input  logic                rst_n,
    // config
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // command stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,   // [31:0] seq, [47:32] handle
    input  logic [MODE_W-1:0]   s_axis_tuser,   // [1:0] mode
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [15:0] resend_handle
    output logic [KIND_W-1:0]   m_axis_tuser,   // [2:0] kind
    output logic                m_axis_tlast
);

    localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LW    = $clog2(WINDOW + 1);
    localparam int CMW   = (LW > CFG_W) ? LW : CFG_W;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MISS_RD,
        ST_SCAN,
        ST_SCAN_RD
    } state_t;

    state_t              state_reg, state_next;
    rwt_mode_t           mode_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SEQ_W-1:0]    next_ack_reg, next_ack_next;
    logic [IW-1:0]       base_reg, base_next;
    logic                ack_ok_reg, ack_ok_next;
    logic [CFG_W-1:0]    win_cfg_reg;
    logic [LW-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                last_pend_reg, last_pend_next;
    logic                out_valid_reg;
    rwt_kind_t           out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_last_reg;

    logic [CMW-1:0]      cfg_ext;
    logic [LW-1:0]       win;
    logic [SEQ_W-1:0]    offset;
    logic                in_window;
    logic [LW-1:0]       n_slide;
    logic [IW:0]         base_sum;
    logic                slot_free;
    logic                accept;
    logic                emit;
    rwt_kind_t           emit_kind;
    logic [HANDLE_W-1:0] emit_handle;
    logic                emit_last;
    rwt_store_cmd_t      store_cmd;
    rwt_occ_cmd_t        occ_cmd;
    logic [IW-1:0]       lidx;
    logic [HANDLE_W-1:0] rd_data;
    logic                occ_at;
    logic                later_any;

    // effective window, saturated to 1..WINDOW
    always_comb
    begin
        cfg_ext = CMW'(win_cfg_reg);
        if (cfg_ext == '0)
        begin
            win = LW'(1);
        end
        else if (cfg_ext > CMW'(WINDOW))
        begin
            win = LW'(WINDOW);
        end
        else
        begin
            win = LW'(cfg_ext);
        end
    end

    // offset into the window and slide arithmetic
    assign offset    = seq_reg - next_ack_reg;
    assign in_window = offset < SEQ_W'(win);
    assign n_slide   = offset[LW-1:0] + LW'(1);
    assign base_sum  = {1'b0, base_reg} + (IW+1)'(n_slide);

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sequencer decisions
    always_comb
    begin
        state_next     = state_reg;
        next_ack_next  = next_ack_reg;
        base_next      = base_reg;
        ack_ok_next    = ack_ok_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        last_pend_next = last_pend_reg;
        emit           = 1'b0;
        emit_kind      = KIND_TRACKED;
        emit_handle    = '0;
        emit_last      = 1'b1;
        store_cmd      = '0;
        occ_cmd        = '0;
        lidx           = offset[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_TRACK:
                    begin
                        if (slot_free)
                        begin
                            emit      = 1'b1;
                            emit_kind = in_window ? KIND_TRACKED : KIND_FULL;
                            if (in_window)
                            begin
                                store_cmd.wr    = 1'b1;
                                occ_cmd.set     = 1'b1;
                                occ_cmd.set_val = (handle_reg != '0);
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_ACK:
                    begin
                        if (slot_free)
                        begin
                            emit      = 1'b1;
                            emit_kind = in_window ? KIND_ACK_APPLIED : KIND_ACK_IGNORED;
                            if (in_window)
                            begin
                                occ_cmd.clear = 1'b1;
                                next_ack_next = next_ack_reg + offset + SEQ_W'(1);
                                if (base_sum >= (IW+1)'(WINDOW))
                                begin
                                    base_next = IW'(base_sum - (IW+1)'(WINDOW));
                                end
                                else
                                begin
                                    base_next = base_sum[IW-1:0];
                                end
                            end
                            ack_ok_next = in_window;
                            state_next  = ST_IDLE;
                        end
                    end
                    MODE_MISS:
                    begin
                        if (ack_ok_reg && in_window && occ_at)
                        begin
                            store_cmd.rd = 1'b1;
                            state_next   = ST_MISS_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_RESEND_ALL:
                    begin
                        k_next     = '0;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MISS_RD:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_RESEND;
                    emit_handle = rd_data;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                lidx = k_reg[IW-1:0];
                if (k_reg >= win)
                begin
                    state_next = ST_IDLE;
                end
                else if (occ_at)
                begin
                    store_cmd.rd   = 1'b1;
                    last_pend_next = !later_any || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                    state_next     = ST_SCAN_RD;
                end
                else
                begin
                    k_next = k_reg + LW'(1);
                end
            end
            ST_SCAN_RD:
            begin
                lidx = k_reg[IW-1:0];
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_RESEND;
                    emit_handle = rd_data;
                    emit_last   = last_pend_reg;
                    k_next      = k_reg + LW'(1);
                    cnt_next    = cnt_reg + CNT_W'(1);
                    state_next  = last_pend_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, window registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_TRACK;
            seq_reg        <= '0;
            handle_reg     <= '0;
            next_ack_reg   <= '0;
            base_reg       <= '0;
            ack_ok_reg     <= 1'b0;
            win_cfg_reg    <= WIN_CFG_RESET;
            k_reg          <= '0;
            cnt_reg        <= '0;
            last_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_TRACKED;
            out_handle_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_ack_reg  <= next_ack_next;
            base_reg      <= base_next;
            ack_ok_reg    <= ack_ok_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            last_pend_reg <= last_pend_next;
            if (cfg_we)
            begin
                win_cfg_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg   <= rwt_mode_t'(s_axis_tuser);
                seq_reg    <= s_axis_tdata[31:0];
                handle_reg <= s_axis_tdata[47:32];
            end
            if (emit)
            begin
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= emit_kind;
                out_handle_reg <= emit_handle;
                out_last_reg   <= emit_last;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_handle_reg;
    assign m_axis_tlast  = out_last_reg;

    rwt_slot_store #(
        .WINDOW (WINDOW)
    ) u_store (
        .clk     (clk),
        .cmd     (store_cmd),
        .base    (base_reg),
        .lidx    (lidx),
        .wr_data (handle_reg),
        .rd_data (rd_data)
    );

    rwt_occ_map #(
        .WINDOW (WINDOW)
    ) u_occ (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (occ_cmd),
        .base      (base_reg),
        .lidx      (lidx),
        .scan_k    (k_reg),
        .win       (win),
        .clr_n     (n_slide),
        .occ_at    (occ_at),
        .later_any (later_any)
    );

    `ASSERT_NEVER(a_base_range, clk, rst_n, {1'b0, base_reg} >= (IW+1)'(WINDOW),
        "ring base out of range")
    `ASSERT_NEVER(a_cnt_limit, clk, rst_n, cnt_reg > CNT_W'(MAX_RESULTS),
        "resend count overrun")
    `ASSERT_CLK(a_accept_exec, clk, rst_n, accept |=> (state_reg == ST_EXEC),
        "accepted transfer not executed")

endmodule

### rtl/core/rwt_slot_store.sv
// Handle memory of the window, addressed by logical slot through the ring base.
module rwt_slot_store
    import rwt_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)(
    input  logic                clk,
    input  rwt_store_cmd_t      cmd,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] base,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] lidx,
    input  logic [HANDLE_W-1:0] wr_data,
    output logic [HANDLE_W-1:0] rd_data
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [HANDLE_W-1:0] mem [WINDOW];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic [IW:0]         addr_sum;
    logic [IW-1:0]       phys;

    // logical slot to physical entry, wrap once around the ring
    always_comb
    begin
        addr_sum = {1'b0, base} + {1'b0, lidx};
        if (addr_sum >= (IW+1)'(WINDOW))
        begin
            addr_sum = addr_sum - (IW+1)'(WINDOW);
        end
        phys = addr_sum[IW-1:0];
    end

    // single port memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[phys] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[phys];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rwt_occ_map.sv
// Per-slot occupancy flags of the window with logical position lookups.
`include "assert_macros.svh"
module rwt_occ_map
    import rwt_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)(
    input  logic         clk,
    input  logic         rst_n,
    input  rwt_occ_cmd_t cmd,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] base,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] lidx,
    input  logic [$clog2(WINDOW+1)-1:0] scan_k,
    input  logic [$clog2(WINDOW+1)-1:0] win,
    input  logic [$clog2(WINDOW+1)-1:0] clr_n,
    output logic         occ_at,
    output logic         later_any
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [WINDOW-1:0] occ_reg;
    logic [WINDOW-1:0] occ_next;
    logic [IW:0]       lpos [WINDOW];
    logic [IW:0]       lx;
    logic [IW:0]       kx;
    logic [IW:0]       wx;
    logic [IW:0]       nx;

    assign lx = {1'b0, lidx};
    assign kx = (IW+1)'(scan_k);
    assign wx = (IW+1)'(win);
    assign nx = (IW+1)'(clr_n);

    // logical position of every physical entry
    always_comb
    begin
        for (int p = 0; p < WINDOW; p++)
        begin
            if ((IW+1)'(p) < {1'b0, base})
            begin
                lpos[p] = (IW+1)'(p) + (IW+1)'(WINDOW) - {1'b0, base};
            end
            else
            begin
                lpos[p] = (IW+1)'(p) - {1'b0, base};
            end
        end
    end

    // flag updates and lookups
    always_comb
    begin
        occ_next  = occ_reg;
        occ_at    = 1'b0;
        later_any = 1'b0;
        for (int p = 0; p < WINDOW; p++)
        begin
            if (cmd.set && (lpos[p] == lx))
            begin
                occ_next[p] = cmd.set_val;
            end
            if (cmd.clear && (lpos[p] < nx))
            begin
                occ_next[p] = 1'b0;
            end
            if (occ_reg[p] && (lpos[p] == lx))
            begin
                occ_at = 1'b1;
            end
            if (occ_reg[p] && (lpos[p] > kx) && (lpos[p] < wx))
            begin
                later_any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `ASSERT_NEVER(a_set_and_clear, clk, rst_n, cmd.set && cmd.clear, "occ set during clear")
    `ASSERT_CLK(a_clear_nonzero, clk, rst_n, cmd.clear |-> (clr_n != '0), "empty slide")
    `ASSERT_CLK(a_set_sticks, clk, rst_n, (cmd.set && cmd.set_val) |=> (occ_reg != '0),
        "occupancy set lost")

endmodule

### tb/retransmit_window_tracker_tb.sv
// Self-checking testbench for the retransmit window tracker: command driver, result checker.
`timescale 1ns / 100ps

module retransmit_window_tracker_tb;
    import rwt_pkg::*;

    localparam int WINDOW        = WINDOW_DEFAULT;
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 3000;  // cycles without any transfer
    localparam int PRINT_LIMIT   = 20;

    typedef struct packed {
        rwt_mode_t   mode;
        logic [31:0] seq;
        logic [15:0] handle;
    } cmd_t;

    typedef struct packed {
        rwt_kind_t   kind;
        logic [15:0] handle;
        logic        last;
    } due_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = WIN_CFG_RESET;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata = '0;     // [31:0] seq, [47:32] handle
    logic [MODE_W-1:0]   s_axis_tuser = '0;     // [1:0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;          // [15:0] resend_handle
    logic [KIND_W-1:0]   m_axis_tuser;          // [2:0] kind
    logic                m_axis_tlast;

    // Command source and expected results
    cmd_t        pending[$];
    due_t        due_results[$];
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on = 1'b1;

    // Window state as the checker sees it
    logic [15:0] slots[WINDOW];
    logic [31:0] ack_base = '0;
    bit          ack_ok = 1'b0;
    logic [5:0]  win_reg = WIN_CFG_RESET;

    // Window state as the stimulus generator tracks it
    logic [31:0] gen_base = '0;
    int unsigned gen_win = WINDOW;

    retransmit_window_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Window size register saturates to 1..WINDOW
    function automatic int unsigned slots_in_use(logic [5:0] v);
        if (v == 0)
            return 1;
        if (v > WINDOW)
            return WINDOW;
        return v;
    endfunction

    function automatic void due_push(rwt_kind_t kind, logic [15:0] h, logic last);
        due_t d;
        d.kind = kind;
        d.handle = h;
        d.last = last;
        due_results.push_back(d);
    endfunction

    // Apply one accepted command to the window and queue what it must produce
    function automatic void window_apply(rwt_mode_t mode, logic [31:0] seq, logic [15:0] handle);
        int unsigned w;
        int unsigned n;
        logic [31:0] offset;
        bit in_win;
        w = slots_in_use(win_reg);
        offset = seq - ack_base;
        in_win = (offset < w);
        n = 0;
        case (mode)
            MODE_TRACK:
            begin
                if (in_win)
                begin
                    slots[offset] = handle;
                    due_push(KIND_TRACKED, 16'h0, 1'b1);
                end
                else
                    due_push(KIND_FULL, 16'h0, 1'b1);
            end
            MODE_ACK:
            begin
                if (in_win)
                begin
                    // slide down by offset+1, empty slots enter at the top
                    for (int unsigned i = 0; i < WINDOW; i++)
                        slots[i] = (i + offset + 1 < WINDOW) ? slots[i + offset + 1] : 16'h0;
                    ack_base = ack_base + offset + 1;
                    ack_ok = 1'b1;
                    due_push(KIND_ACK_APPLIED, 16'h0, 1'b1);
                end
                else
                begin
                    ack_ok = 1'b0;
                    due_push(KIND_ACK_IGNORED, 16'h0, 1'b1);
                end
            end
            MODE_MISS:
            begin
                if (ack_ok && in_win && slots[offset] != 16'h0)
                    due_push(KIND_RESEND, slots[offset], 1'b1);
            end
            default:
            begin
                for (int unsigned i = 0; i < w && n < MAX_RESULTS; i++)
                begin
                    if (slots[i] != 16'h0)
                    begin
                        due_push(KIND_RESEND, slots[i], 1'b0);
                        n++;
                    end
                end
                if (n > 0)
                    due_results[due_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Stimulus helpers; the generator follows its own acks to aim seq at the window
    function automatic void queue_item(rwt_mode_t mode, logic [31:0] seq, logic [15:0] handle);
        cmd_t c;
        logic [31:0] offset;
        c.mode = mode;
        c.seq = seq;
        c.handle = handle;
        pending.push_back(c);
        items_queued++;
        offset = seq - gen_base;
        if (mode == MODE_ACK && offset < gen_win)
            gen_base = gen_base + offset + 1;
    endfunction

    function automatic void queue_noise();
        logic [31:0] seq;
        seq = ($urandom_range(0, 1) == 0) ? $urandom : gen_base + $urandom_range(0, 2 * gen_win);
        queue_item(rwt_mode_t'($urandom_range(0, 3)), seq, 16'($urandom));
    endfunction

    // Typical exchange: track some packets, maybe resend all, report misses, ack, report again
    function automatic void queue_burst();
        int unsigned n;
        int unsigned off;
        int unsigned i;
        bit fill;
        fill = ($urandom_range(0, 9) == 0);
        n = fill ? gen_win : $urandom_range(1, (gen_win < 8) ? gen_win : 8);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0, 1:    off = gen_win - 1;
                2:       off = gen_win;
                default: off = $urandom_range(0, gen_win - 1);
            endcase
            if (fill)
                off = i;
            queue_item(MODE_TRACK, gen_base + off,
                       ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom_range(1, 65535)));
        end
        if ($urandom_range(0, 2) == 0)
            queue_item(MODE_RESEND_ALL, $urandom, 16'($urandom));
        queue_item(MODE_MISS, gen_base + $urandom_range(0, gen_win - 1), 16'($urandom));
        off = ($urandom_range(0, 5) == 0) ? gen_win + $urandom_range(0, 3)
                                          : $urandom_range(0, gen_win - 1);
        queue_item(MODE_ACK, gen_base + off, 16'h0);
        repeat ($urandom_range(1, 3))
            queue_item(MODE_MISS, gen_base + $urandom_range(0, gen_win), 16'h0);
        if ($urandom_range(0, 3) == 0)
            queue_item(MODE_RESEND_ALL, 32'h0, 16'h0);
    endfunction

    task automatic wait_drained();
        while (items_taken != items_queued || due_results.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only once the block has gone quiet
    task automatic set_window(logic [5:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_reg = v;
        gen_win = slots_in_use(v);
    endtask

    // Command driver
    always @(posedge clk)
    begin
        cmd_t c;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_gap != 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                c = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {c.handle, c.seq};
                s_axis_tuser <= c.mode;
                if (idle_on && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 17);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_gap != 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 17);
        end
    end

    // Monitor: check the result transfer first, then predict from the command transfer
    always @(posedge clk)
    begin
        due_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d handle %h last %b",
                                              m_axis_tuser, m_axis_tdata, m_axis_tlast));
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata !== want.handle
                        || m_axis_tlast !== want.last)
                        report_mismatch($sformatf(
                            "result %0d: kind %0d handle %h last %b, want %0d %h %b",
                            results_seen, m_axis_tuser, m_axis_tdata, m_axis_tlast,
                            want.kind, want.handle, want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                window_apply(rwt_mode_t'(s_axis_tuser), s_axis_tdata[31:0],
                             s_axis_tdata[47:32]);
                items_taken++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d commands taken of %0d, %0d results outstanding",
                         items_taken, items_queued, due_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [5:0]  win_plan[5];
        int unsigned plan_len[5];
        int unsigned target;
        for (int i = 0; i < WINDOW; i++)
            slots[i] = 16'h0;
        win_plan = '{6'd1, 6'd0, 6'd63, 6'($urandom_range(2, 31)), 6'd32};
        plan_len = '{60, 40, 75, 75, 80};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset window of 32 slots
        queue_item(MODE_TRACK, 32'd0, 16'hFFFF);
        queue_item(MODE_TRACK, 32'd31, 16'h0001);          // top slot
        queue_item(MODE_TRACK, 32'd32, 16'h1234);          // one past the window
        queue_item(MODE_TRACK, 32'hFFFF_FFFF, 16'h8000);   // behind the base
        queue_item(MODE_MISS, 32'd0, 16'h0);               // no ack seen yet
        queue_item(MODE_RESEND_ALL, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(MODE_ACK, 32'd40, 16'h0);               // outside, ignored
        queue_item(MODE_TRACK, 32'd5, 16'h0);              // handle zero
        queue_item(MODE_ACK, 32'd0, 16'h0);                // slide by one
        queue_item(MODE_MISS, 32'd31, 16'h0);              // hit
        queue_item(MODE_MISS, 32'd2, 16'h0);               // empty slot
        queue_item(MODE_MISS, 32'd100, 16'h0);             // outside
        queue_item(MODE_ACK, 32'd31, 16'h0);               // slide by 31
        queue_item(MODE_RESEND_ALL, 32'h0, 16'h0);         // empty store
        queue_item(MODE_TRACK, 32'd32, 16'hABCD);
        queue_item(MODE_TRACK, 32'd63, 16'h5555);
        queue_item(MODE_ACK, 32'hFFFF_FFFF, 16'h0);        // ignored, drops ack flag
        queue_item(MODE_MISS, 32'd32, 16'h0);              // suppressed
        queue_item(MODE_ACK, 32'd32, 16'h0);
        queue_item(MODE_MISS, 32'd63, 16'h0);
        queue_item(MODE_TRACK, 32'd64, 16'hFFFF);
        queue_item(MODE_RESEND_ALL, 32'h0, 16'h0);
        queue_item(MODE_ACK, 32'd64, 16'h0);               // full slide of 32

        // Random phases over several window settings; the last one runs flat out
        for (int ph = 0; ph < 5; ph++)
        begin
            set_window(win_plan[ph]);
            idle_on = (ph != 4);
            target = items_queued + plan_len[ph];
            while (items_queued < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_noise();
                else
                    queue_burst();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d results, window settings 32 1 0 63 %0d 32",
                 items_taken, results_seen, win_plan[3]);
        $display("mismatches: %0d, results still due: %0d", mismatches, due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rwt_pkg.sv
rtl/core/rwt_slot_store.sv
rtl/core/rwt_occ_map.sv
rtl/core/retransmit_window_tracker.sv
tb/retransmit_window_tracker_tb.sv
